// File: hdl/ubx_frame_parser_macros.svh
// assertion macros shared by the frame parser rtl
`ifndef UBX_FRAME_PARSER_MACROS_SVH
`define UBX_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define UBX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubx same-cycle check failed");

// next-cycle implication
`define UBX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubx next-cycle check failed");

`endif

// File: hdl/ubx_pkg.sv
// types and constants of the ubx frame parser
`default_nettype none
package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam int unsigned MAX_PAYLOAD = 256;

    typedef enum logic [3:0] {
        ST_HUNT     = 4'd0,
        ST_SYNC2    = 4'd1,
        ST_CLASS    = 4'd2,
        ST_ID       = 4'd3,
        ST_LEN_LO   = 4'd4,
        ST_LEN_HI   = 4'd5,
        ST_PAYLOAD  = 4'd6,
        ST_CK_A     = 4'd7,
        ST_CK_B     = 4'd8
    } t_step;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_BAD_A  = 2'd2,
        EV_BAD_B  = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx;

    typedef struct packed {
        logic        payload_strobe;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
        t_event      event_res;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [15:0] good_frames;
        logic [15:0] bad_frames;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/ubx_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
`default_nettype none
interface ubx_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/ubx_fsm.sv
// frame state machine, fletcher sums, header capture and frame counters
`include "ubx_frame_parser_macros.svh"
`default_nettype none
module ubx_fsm #(
    parameter int unsigned MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_byte,
    output ubx_pkg::t_result      o_res
);

    ubx_pkg::t_step r_step, n_step;
    logic [7:0]     r_sum_a, n_sum_a;
    logic [7:0]     r_sum_b, n_sum_b;
    logic [7:0]     r_class, n_class;
    logic [7:0]     r_id, n_id;
    logic [15:0]    r_len, n_len;
    logic [15:0]    r_count, n_count;
    logic [15:0]    r_good, n_good;
    logic [15:0]    r_bad, n_bad;

    logic [15:0]    w_len_full;
    logic [16:0]    w_count_inc;
    logic [7:0]     w_add_a;
    logic [7:0]     w_add_b;
    logic           w_in_buf;

    assign w_len_full  = {i_byte, r_len[7:0]};
    assign w_count_inc = {1'b0, r_count} + 17'd1;
    assign w_add_a     = r_sum_a + i_byte;
    assign w_add_b     = r_sum_b + w_add_a;
    assign w_in_buf    = {1'b0, r_count} < 17'(MAX_PAYLOAD);

    // next state
    always_comb begin
        n_step = ubx_pkg::ST_HUNT;
        unique case (r_step)
            ubx_pkg::ST_HUNT: begin
                n_step = (i_byte == ubx_pkg::SYNC_FIRST) ? ubx_pkg::ST_SYNC2 : ubx_pkg::ST_HUNT;
            end
            ubx_pkg::ST_SYNC2: begin
                n_step = (i_byte == ubx_pkg::SYNC_SECOND) ? ubx_pkg::ST_CLASS : ubx_pkg::ST_HUNT;
            end
            ubx_pkg::ST_CLASS:  n_step = ubx_pkg::ST_ID;
            ubx_pkg::ST_ID:     n_step = ubx_pkg::ST_LEN_LO;
            ubx_pkg::ST_LEN_LO: n_step = ubx_pkg::ST_LEN_HI;
            ubx_pkg::ST_LEN_HI: begin
                n_step = (w_len_full == 16'd0) ? ubx_pkg::ST_CK_A : ubx_pkg::ST_PAYLOAD;
            end
            ubx_pkg::ST_PAYLOAD: begin
                n_step = (w_count_inc == {1'b0, r_len}) ? ubx_pkg::ST_CK_A
                                                       : ubx_pkg::ST_PAYLOAD;
            end
            ubx_pkg::ST_CK_A: begin
                n_step = (r_sum_a == i_byte) ? ubx_pkg::ST_CK_B : ubx_pkg::ST_HUNT;
            end
            ubx_pkg::ST_CK_B:   n_step = ubx_pkg::ST_HUNT;
            default:            n_step = ubx_pkg::ST_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_count = r_count;
        n_good  = r_good;
        n_bad   = r_bad;
        o_res.payload_strobe = 1'b0;
        o_res.payload_index  = 8'd0;
        o_res.payload_byte   = 8'd0;
        o_res.event_res      = ubx_pkg::EV_NONE;
        unique case (r_step) inside
            ubx_pkg::ST_HUNT, ubx_pkg::ST_SYNC2: begin
            end
            ubx_pkg::ST_CLASS: begin
                n_class = i_byte;
                n_sum_a = i_byte;
                n_sum_b = i_byte;
            end
            ubx_pkg::ST_ID: begin
                n_id    = i_byte;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
            end
            ubx_pkg::ST_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
            end
            ubx_pkg::ST_LEN_HI: begin
                n_len   = w_len_full;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_count = 16'd0;
            end
            ubx_pkg::ST_PAYLOAD: begin
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_count = w_count_inc[15:0];
                if (w_in_buf) begin
                    o_res.payload_strobe = 1'b1;
                    o_res.payload_index  = r_count[7:0];
                    o_res.payload_byte   = i_byte;
                end
            end
            ubx_pkg::ST_CK_A: begin
                if (r_sum_a != i_byte) begin
                    n_bad           = r_bad + 16'd1;
                    o_res.event_res = ubx_pkg::EV_BAD_A;
                end
            end
            ubx_pkg::ST_CK_B: begin
                if (r_sum_b != i_byte) begin
                    n_bad           = r_bad + 16'd1;
                    o_res.event_res = ubx_pkg::EV_BAD_B;
                end else begin
                    n_good          = r_good + 16'd1;
                    o_res.event_res = ubx_pkg::EV_ACCEPT;
                end
            end
            default: begin
            end
        endcase
        o_res.frame_class  = n_class;
        o_res.frame_id     = n_id;
        o_res.frame_length = n_len;
        o_res.good_frames  = n_good;
        o_res.bad_frames   = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ubx_pkg::ST_HUNT;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_class <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_good  <= 16'd0;
            r_bad   <= 16'd0;
        end else if (i_en) begin
            r_step  <= n_step;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

    `UBX_ASSERT_NOW(a_strobe_in_payload, i_clk, i_rst_n, i_en && o_res.payload_strobe, r_step == ubx_pkg::ST_PAYLOAD)
    `UBX_ASSERT_NEXT(a_event_rehunts, i_clk, i_rst_n, i_en && (o_res.event_res != ubx_pkg::EV_NONE), r_step == ubx_pkg::ST_HUNT)
    `UBX_ASSERT_NEXT(a_good_steps, i_clk, i_rst_n, i_en && (o_res.event_res == ubx_pkg::EV_ACCEPT), r_good == $past(r_good) + 16'd1)
    `UBX_ASSERT_NEXT(a_bad_steps, i_clk, i_rst_n, i_en && (o_res.event_res == ubx_pkg::EV_BAD_A), r_bad == $past(r_bad) + 16'd1)

endmodule
`default_nettype wire

// File: hdl/ubx_out_stage.sv
// result register between the state machine and the output channel
`include "ubx_frame_parser_macros.svh"
`default_nettype none
module ubx_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire ubx_pkg::t_result i_res,
    output logic                  o_adv,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ubx_pkg::t_result      o_res
);

    logic             r_valid;
    ubx_pkg::t_result r_res;

    // the register may take a new result when empty or when drained this cycle
    assign o_adv   = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_load) begin
            r_res <= i_res;
        end
    end

    `UBX_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_load && r_valid && !i_ready, !o_adv)
    `UBX_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load && o_adv, r_valid)
    `UBX_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_valid && !i_ready, r_res == $past(r_res))

endmodule
`default_nettype wire

// File: hdl/ubx_frame_parser.sv
// top level of the ubx frame parser: input register, state machine, result register
// a byte moves through input register and state machine into the result register
// throughput: one byte per cycle unless output stalls; one state update per byte
// the input register refills in the same cycle that the result register drains
// reset (synchronous, active low) empties both registers and returns to sync hunting
// counters, sums and header fields clear to zero on reset
`default_nettype none
module ubx_frame_parser #(
    parameter int unsigned MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ubx_stream_if.sink   i_rx,
    ubx_stream_if.source o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             w_adv;
    logic             w_step;
    ubx_pkg::t_result w_res;
    ubx_pkg::t_result w_out;
    logic             w_out_valid;

    assign w_step     = r_in_valid && w_adv;
    assign i_rx.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.payload.rx_byte;
        end
    end

    ubx_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    ubx_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid),
        .i_res   (w_res),
        .o_adv   (w_adv),
        .o_valid (w_out_valid),
        .i_ready (o_res.ready),
        .o_res   (w_out)
    );

    assign o_res.valid   = w_out_valid;
    assign o_res.payload = w_out;

endmodule
`default_nettype wire
